// ===== hdl/assert_macros.svh =====
// Assertion helpers used by timed_event_slot_queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define TESQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tesq assertion failed");

// Check on every clock edge, reset included.
`define TESQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("tesq assertion failed");

`endif

// ===== hdl/tesq_pkg.sv =====
`timescale 1ns / 1ps

package tesq_pkg;

  localparam int unsigned IDX_W = 6;
  localparam int unsigned PROD_W = 26;
  localparam logic [9:0] US_PER_MS = 10'd1000;

  typedef logic [IDX_W-1:0] slot_idx_t;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [63:0] start_time;
    logic [7:0]  channel;
    logic [7:0]  strength;
    logic [15:0] duration_ms;
    logic [15:0] drive_freq;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] evt_time;
    logic [7:0]  evt_channel;
    logic [7:0]  evt_strength;
    logic [15:0] evt_freq;
    logic        evt_is_on;
    logic [4:0]  occupied;
    logic        is_empty;
  } rsp_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic        found;
    logic [63:0] evt_time;
    logic [31:0] payload;
    logic        is_on;
    slot_idx_t   idx_k;
    logic        free_a;
    slot_idx_t   idx_a;
    logic        free_b;
    slot_idx_t   idx_b;
  } tok_t;

  // Update broadcast to all cells at the end of a sweep.
  typedef struct packed {
    logic        wr_a;
    logic        wr_b;
    logic        free;
    logic        clr;
    slot_idx_t   idx_a;
    slot_idx_t   idx_b;
    slot_idx_t   idx_k;
    logic [63:0] time_a;
    logic [63:0] time_b;
    logic [31:0] pay_a;
    logic [31:0] pay_b;
  } commit_t;

endpackage

// ===== hdl/tesq_cell.sv =====
`timescale 1ns / 1ps

module tesq_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_vld_i,
  input  tesq_pkg::tok_t    tok_i,
  output logic              tok_vld_o,
  output tesq_pkg::tok_t    tok_o,
  input  tesq_pkg::commit_t cmt_i
);
  import tesq_pkg::*;

  localparam slot_idx_t MyIdx = slot_idx_t'(IDX);

  logic        valid_q;
  logic [63:0] time_q;
  logic [31:0] pay_q;
  logic        on_q;
  logic        tok_vld_q;
  tok_t        tok_q;
  tok_t        tok_d;

  always_comb begin
    tok_d = tok_i;
    if (valid_q && (!tok_i.found || (time_q < tok_i.evt_time))) begin
      tok_d.found    = 1'b1;
      tok_d.evt_time = time_q;
      tok_d.payload  = pay_q;
      tok_d.is_on    = on_q;
      tok_d.idx_k    = MyIdx;
    end
    if (!valid_q) begin
      if (!tok_i.free_a) begin
        tok_d.free_a = 1'b1;
        tok_d.idx_a  = MyIdx;
      end else if (!tok_i.free_b) begin
        tok_d.free_b = 1'b1;
        tok_d.idx_b  = MyIdx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
      if (cmt_i.clr) begin
        valid_q <= 1'b0;
      end else if (cmt_i.wr_a && (cmt_i.idx_a == MyIdx)) begin
        valid_q <= 1'b1;
      end else if (cmt_i.wr_b && (cmt_i.idx_b == MyIdx)) begin
        valid_q <= 1'b1;
      end else if (cmt_i.free && (cmt_i.idx_k == MyIdx)) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_vld_i) begin
      tok_q <= tok_d;
    end
    if (cmt_i.wr_a && (cmt_i.idx_a == MyIdx)) begin
      time_q <= cmt_i.time_a;
      pay_q  <= cmt_i.pay_a;
      on_q   <= 1'b1;
    end else if (cmt_i.wr_b && (cmt_i.idx_b == MyIdx)) begin
      time_q <= cmt_i.time_b;
      pay_q  <= cmt_i.pay_b;
      on_q   <= 1'b0;
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;

endmodule

// ===== hdl/timed_event_slot_queue.sv =====
`timescale 1ns / 1ps
// Timed event queue over a row of SLOTS event slots.
// Command channel: a transaction is taken on a rising edge with start high and
// busy low; req_i carries the command (enqueue pair, dequeue, peek, clear) and
// the event fields. Busy stays high until the result is produced.
// Result channel: done_o is high for exactly one cycle with rsp_o valid; the
// receiver must take it then, it cannot hold results off.
// Commands: one command is in flight at a time; a new command can be taken in
// the same cycle that done_o is high. The time per command is set by the search
// token, which walks the cell row one slot per cycle collecting the earliest
// event and the two lowest free slots; the slot updates are applied to all
// cells in the cycle the token leaves the row.
// The deactivate time start_time + duration_ms*1000 is built in two register
// stages while the token walks.
// Reset: all slots empty, no command in flight, occupied count zero.
`include "assert_macros.svh"

module timed_event_slot_queue #(
  parameter int unsigned SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  tesq_pkg::req_t req_i,
  output logic           done_o,
  output tesq_pkg::rsp_t rsp_o
);
  import tesq_pkg::*;

  localparam int unsigned CW = $clog2(SLOTS + 1);

  logic              busy_q;
  logic              launch_q;
  logic              done_q;
  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     cnt_d;
  logic [CW+4:0]     cnt_ext;
  req_t              req_q;
  logic [PROD_W-1:0] prod_q;
  logic [63:0]       off_time_q;
  rsp_t              rsp_q;
  rsp_t              rsp_d;
  commit_t           cmt;
  logic              accept;

  logic [SLOTS:0]    vld;
  tok_t              tok [SLOTS+1];

  assign accept = start && !busy_q;

  assign vld[0] = launch_q;
  assign tok[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    tesq_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_vld_i (vld[i]),
      .tok_i     (tok[i]),
      .tok_vld_o (vld[i+1]),
      .tok_o     (tok[i+1]),
      .cmt_i     (cmt)
    );
  end

  always_comb begin
    cmt        = '0;
    cmt.idx_a  = tok[SLOTS].idx_a;
    cmt.idx_b  = tok[SLOTS].idx_b;
    cmt.idx_k  = tok[SLOTS].idx_k;
    cmt.time_a = req_q.start_time;
    cmt.time_b = off_time_q;
    cmt.pay_a  = {req_q.drive_freq, req_q.strength, req_q.channel};
    cmt.pay_b  = {24'd0, req_q.channel};
    cnt_d      = cnt_q;
    rsp_d      = '0;
    rsp_d.evt_time = '1;
    if (vld[SLOTS]) begin
      unique case (req_q.cmd)
        CMD_ENQ: begin
          if (tok[SLOTS].free_a && tok[SLOTS].free_b) begin
            cmt.wr_a  = 1'b1;
            cmt.wr_b  = 1'b1;
            rsp_d.ok  = 1'b1;
            cnt_d     = cnt_q + CW'(2);
          end
        end
        CMD_DEQ, CMD_PEEK: begin
          if (tok[SLOTS].found) begin
            rsp_d.ok           = 1'b1;
            rsp_d.evt_time     = tok[SLOTS].evt_time;
            rsp_d.evt_channel  = tok[SLOTS].payload[7:0];
            rsp_d.evt_strength = tok[SLOTS].payload[15:8];
            rsp_d.evt_freq     = tok[SLOTS].payload[31:16];
            rsp_d.evt_is_on    = tok[SLOTS].is_on;
            if (req_q.cmd == CMD_DEQ) begin
              cmt.free = 1'b1;
              cnt_d    = cnt_q - CW'(1);
            end
          end
        end
        CMD_CLEAR: begin
          cmt.clr  = 1'b1;
          rsp_d.ok = 1'b1;
          cnt_d    = '0;
        end
        default: begin
        end
      endcase
    end
    cnt_ext        = {5'd0, cnt_d};
    rsp_d.occupied = cnt_ext[4:0];
    rsp_d.is_empty = (cnt_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      launch_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      launch_q <= accept;
      done_q   <= vld[SLOTS];
      cnt_q    <= cnt_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (vld[SLOTS]) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    prod_q     <= PROD_W'(req_q.duration_ms) * PROD_W'(US_PER_MS);
    off_time_q <= req_q.start_time + 64'(prod_q);
    if (vld[SLOTS]) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `TESQ_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!done_o && !busy))
  `TESQ_ASSERT(a_done_frees, done_o |-> !busy)
  `TESQ_ASSERT(a_launch_busy, launch_q |-> busy_q)
  `TESQ_ASSERT(a_tail_done, vld[SLOTS] |=> done_o)
  `TESQ_ASSERT(a_count_range, cnt_q <= CW'(SLOTS))
  `TESQ_ASSERT(a_fail_time, (done_o && !rsp_o.ok) |-> (rsp_o.evt_time == '1))

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tesq_pkg::*;

  localparam int SLOTS = 16;
  localparam int RANDOM_ITEMS = 2000;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = SLOTS + 8;

  typedef struct {
    bit          valid;
    logic [63:0] at;
    logic [7:0]  chan;
    logic [7:0]  amp;
    logic [15:0] freq;
    bit          is_on;
  } slot_t;

  class slot_queue_tracker;
    slot_t slots[SLOTS];
    rsp_t  expected_rsps[$];
    int    errors;

    function new();
      foreach (slots[i]) slots[i].valid = 1'b0;
      errors = 0;
    endfunction

    function int pending_count();
      return expected_rsps.size();
    endfunction

    function void note_command(req_t r);
      rsp_t e;
      int   a;
      int   b;
      int   k;
      int   n;
      e = '0;
      e.evt_time = '1;
      a = -1;
      b = -1;
      k = -1;
      n = 0;
      case (r.cmd)
        CMD_ENQ: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!slots[i].valid) begin
              if (a < 0) a = i;
              else if (b < 0) b = i;
            end
          end
          if (b >= 0) begin
            slots[a] = '{1'b1, r.start_time, r.channel, r.strength, r.drive_freq, 1'b1};
            slots[b] = '{1'b1, r.start_time + 64'(r.duration_ms) * 64'd1000,
                         r.channel, 8'd0, 16'd0, 1'b0};
            e.ok = 1'b1;
          end
        end
        CMD_DEQ, CMD_PEEK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slots[i].valid && (k < 0 || slots[i].at < slots[k].at)) k = i;
          end
          if (k >= 0) begin
            e.ok = 1'b1;
            e.evt_time = slots[k].at;
            e.evt_channel = slots[k].chan;
            e.evt_strength = slots[k].amp;
            e.evt_freq = slots[k].freq;
            e.evt_is_on = slots[k].is_on;
            if (r.cmd == CMD_DEQ) slots[k].valid = 1'b0;
          end
        end
        default: begin
          foreach (slots[i]) slots[i].valid = 1'b0;
          e.ok = 1'b1;
        end
      endcase
      foreach (slots[i]) if (slots[i].valid) n++;
      e.occupied = 5'(n);
      e.is_empty = (n == 0);
      expected_rsps.push_back(e);
    endfunction

    function bit field_differs(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      bit   bad;
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected transaction on result port, actual %0h", $time, got);
        errors++;
        return;
      end
      e = expected_rsps.pop_front();
      bad = field_differs("ok", 64'(e.ok), 64'(got.ok));
      bad |= field_differs("evt_time", e.evt_time, got.evt_time);
      bad |= field_differs("evt_channel", 64'(e.evt_channel), 64'(got.evt_channel));
      bad |= field_differs("evt_strength", 64'(e.evt_strength), 64'(got.evt_strength));
      bad |= field_differs("evt_freq", 64'(e.evt_freq), 64'(got.evt_freq));
      bad |= field_differs("evt_is_on", 64'(e.evt_is_on), 64'(got.evt_is_on));
      bad |= field_differs("occupied", 64'(e.occupied), 64'(got.occupied));
      bad |= field_differs("is_empty", 64'(e.is_empty), 64'(got.is_empty));
      if (bad) errors++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  slot_queue_tracker tracker;
  int burst_left;
  int stall_cycles;

  timed_event_slot_queue #(.SLOTS(SLOTS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) tracker.check_response(rsp_o);
      if (start && !busy) tracker.note_command(req_i);
      if ((start && !busy) || done_o) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  function automatic req_t make_req(cmd_e c, logic [63:0] t, logic [7:0] ch, logic [7:0] st,
                                    logic [15:0] dur, logic [15:0] fq);
    req_t r;
    r.cmd = c;
    r.start_time = t;
    r.channel = ch;
    r.strength = st;
    r.duration_ms = dur;
    r.drive_freq = fq;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int   w;
    w = $urandom_range(0, 99);
    r.cmd = (w < 45) ? CMD_ENQ : (w < 75) ? CMD_DEQ : (w < 93) ? CMD_PEEK : CMD_CLEAR;
    w = $urandom_range(0, 9);
    if (w < 4) r.start_time = 64'($urandom_range(0, 7));
    else if (w < 6) r.start_time = '1 - 64'($urandom_range(0, 70000000));
    else r.start_time = {$urandom, $urandom};
    r.channel = 8'($urandom_range(0, 255));
    r.strength = 8'($urandom_range(0, 255));
    r.drive_freq = 16'($urandom_range(0, 65535));
    w = $urandom_range(0, 9);
    r.duration_ms = (w == 0) ? 16'd0 : (w == 1) ? 16'hffff : 16'($urandom_range(0, 65535));
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        start <= 1'b0;
        req_i <= random_req();
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  initial begin
    tracker = new();
    burst_left = 0;
    stall_cycles = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    issue(make_req(CMD_PEEK, '1, 8'hff, 8'hff, 16'hffff, 16'hffff));
    issue(make_req(CMD_DEQ, '0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    issue(make_req(CMD_CLEAR, '0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    issue(make_req(CMD_ENQ, '0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    issue(make_req(CMD_PEEK, '0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    issue(make_req(CMD_ENQ, '1, 8'hff, 8'hff, 16'hffff, 16'hffff));
    repeat (5) issue(make_req(CMD_DEQ, '0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    for (int i = 0; i < SLOTS / 2; i++) begin
      issue(make_req(CMD_ENQ, 64'(1000 - 100 * (i / 2)), 8'(i + 1), 8'(16 * i + 3),
                     16'(i % 3), 16'(4000 + i)));
    end
    issue(make_req(CMD_ENQ, 64'd5, 8'h55, 8'haa, 16'd1, 16'h1234));
    issue(make_req(CMD_DEQ, '0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    issue(make_req(CMD_ENQ, 64'd5, 8'h55, 8'haa, 16'd1, 16'h1234));
    issue(make_req(CMD_PEEK, '0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    issue(make_req(CMD_CLEAR, '1, 8'hff, 8'hff, 16'hffff, 16'hffff));
    issue(make_req(CMD_PEEK, '0, 8'h00, 8'h00, 16'h0000, 16'h0000));

    repeat (RANDOM_ITEMS) issue(random_req());
    start <= 1'b0;

    while (tracker.pending_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
